FILE: rtl/sbmq_pkg.sv
// sbmq_pkg: shared constants for the shared-buffer multi-queue block
// default sizes, field widths and result status codes
// no dependencies
`timescale 1ns / 1ps

package sbmq_pkg;

    localparam int DEPTH_DEF  = 16;
    localparam int QUEUES_DEF = 4;

    localparam int DATA_W = 32;
    localparam int QID_W  = 2;
    localparam int ST_W   = 2;

    localparam logic MODE_ENQ = 1'b0;
    localparam logic MODE_DEQ = 1'b1;

    localparam logic [ST_W-1:0] ST_DONE  = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
    localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;

endpackage

FILE: rtl/shared_buffer_multi_queue.sv
// shared_buffer_multi_queue: fifo queues sharing one entry store via linked lists
// uses sbmq_pkg for sizes and status codes, sbmq_ram for all stores
//
// usage:
//   slave channel s_*: one beat is one request. s_tuser = {queue_id, mode}
//   (mode 0 enqueue, 1 dequeue), s_tdata = word to enqueue.
//   master channel m_*: one result beat per request. m_tdata = dequeued word
//   (zero otherwise), m_tuser = status (done, no free entry, queue empty).
//   a small sequencer walks each request through the ram ports: queue
//   head/tail read, then entry link/data read, then the link writes. the
//   link ram has a single write port, so an enqueue takes a second write state.
//   an enqueue passes the read, write and second write states, a dequeue
//   the read and write states, a rejected request only the read state;
//   each then waits in the output state. s_tready is high only while the
//   sequencer is idle, so a new request is not taken until the last has left it.
//   the result sits in an output register; a new request is accepted while
//   it waits, and the sequencer holds the next result until it is taken.
//   reset makes every queue empty and the whole store free. entries not yet
//   handed out are tracked by a fill count, so no clearing pass is needed.
`timescale 1ns / 1ps

module shared_buffer_multi_queue #(
    parameter int DEPTH  = sbmq_pkg::DEPTH_DEF,
    parameter int QUEUES = sbmq_pkg::QUEUES_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [sbmq_pkg::DATA_W-1:0] s_tdata,   // [31:0] data_in
    input  logic [sbmq_pkg::QID_W:0]    s_tuser,   // [0] mode, [2:1] queue_id
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [sbmq_pkg::DATA_W-1:0] m_tdata,   // [31:0] data_out
    output logic [sbmq_pkg::ST_W-1:0]   m_tuser    // [1:0] status
);

    localparam int PW = $clog2(DEPTH + 1);
    localparam int IW = $clog2(DEPTH);
    localparam int QW = (QUEUES > 1) ? $clog2(QUEUES) : 1;
    localparam logic [PW-1:0] NIL = PW'(DEPTH);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RDQ  = 3'd1;
    localparam logic [2:0] S_ENQ  = 3'd2;
    localparam logic [2:0] S_ENQ2 = 3'd3;
    localparam logic [2:0] S_DEQ  = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    logic [2:0]                      state_reg, state_next;
    logic                            mode_reg, mode_next;
    logic [sbmq_pkg::QID_W-1:0]      q_reg, q_next;
    logic [sbmq_pkg::DATA_W-1:0]     word_reg, word_next;
    logic [PW-1:0]                   e_reg, e_next;
    logic                            hempty_reg, hempty_next;
    logic [PW-1:0]                   free_head_reg, free_head_next;
    logic [PW-1:0]                   fill_reg, fill_next;
    logic [QUEUES-1:0]               head_vld_reg, head_vld_next;
    logic [sbmq_pkg::DATA_W-1:0]     res_data_reg, res_data_next;
    logic [sbmq_pkg::ST_W-1:0]       res_status_reg, res_status_next;
    logic                            out_valid_reg, out_valid_next;
    logic [sbmq_pkg::DATA_W-1:0]     out_data_reg, out_data_next;
    logic [sbmq_pkg::ST_W-1:0]       out_status_reg, out_status_next;

    // ram ports
    logic [QW-1:0]               q_raddr, q_waddr;
    logic                        head_we, tail_we;
    logic [PW-1:0]               head_wdata, head_rd;
    logic [IW-1:0]               tail_rd;
    logic                        link_we, data_we;
    logic [IW-1:0]               link_waddr, ent_raddr;
    logic [PW-1:0]               link_wdata, link_rd;
    logic [sbmq_pkg::DATA_W-1:0] data_rd;

    logic          in_range;
    logic          head_vld_q;
    logic          head_live;
    logic [PW-1:0] chk_ptr;
    logic          chk_ok;
    logic [PW-1:0] e_sel;
    logic          fill_hit;
    logic [PW-1:0] link_eff;
    logic          out_load;

    assign q_waddr  = QW'(q_reg);
    assign in_range = (int'(q_reg) < QUEUES);
    assign head_vld_q = in_range ? head_vld_reg[q_waddr] : 1'b0;
    assign head_live  = head_vld_q && (head_rd < NIL);

    // shared pointer check: free head while deciding, queue tail while linking
    assign chk_ptr = (state_reg == S_ENQ) ? PW'(tail_rd) : free_head_reg;
    assign chk_ok  = (chk_ptr < NIL);

    assign e_sel = (mode_reg == sbmq_pkg::MODE_DEQ) ? head_rd : free_head_reg;

    // entries at or above the fill count were never handed out: link is i+1
    assign fill_hit = (e_reg >= fill_reg);
    assign link_eff = fill_hit ? (e_reg + PW'(1)) : link_rd;

    assign q_raddr   = (state_reg == S_IDLE) ? QW'(s_tuser[sbmq_pkg::QID_W:1]) : q_waddr;
    assign ent_raddr = (state_reg == S_RDQ) ? e_sel[IW-1:0] : e_reg[IW-1:0];

    assign s_tready = (state_reg == S_IDLE);
    assign out_load = (state_reg == S_OUT) && (!out_valid_reg || m_tready);

    always_comb
    begin
        state_next      = state_reg;
        mode_next       = mode_reg;
        q_next          = q_reg;
        word_next       = word_reg;
        e_next          = e_reg;
        hempty_next     = hempty_reg;
        free_head_next  = free_head_reg;
        fill_next       = fill_reg;
        head_vld_next   = head_vld_reg;
        res_data_next   = res_data_reg;
        res_status_next = res_status_reg;
        head_we    = 1'b0;
        head_wdata = e_reg;
        tail_we    = 1'b0;
        link_we    = 1'b0;
        link_waddr = e_reg[IW-1:0];
        link_wdata = NIL;
        data_we    = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    mode_next  = s_tuser[0];
                    q_next     = s_tuser[sbmq_pkg::QID_W:1];
                    word_next  = s_tdata;
                    state_next = S_RDQ;
                end
            end
            S_RDQ:
            begin
                hempty_next = !head_live;
                e_next      = e_sel;
                if (mode_reg == sbmq_pkg::MODE_ENQ)
                begin
                    if (!in_range || !chk_ok)
                    begin
                        res_data_next   = '0;
                        res_status_next = sbmq_pkg::ST_FULL;
                        state_next      = S_OUT;
                    end
                    else
                    begin
                        state_next = S_ENQ;
                    end
                end
                else
                begin
                    if (!head_live)
                    begin
                        res_data_next   = '0;
                        res_status_next = sbmq_pkg::ST_EMPTY;
                        state_next      = S_OUT;
                    end
                    else
                    begin
                        state_next = S_DEQ;
                    end
                end
            end
            S_ENQ:
            begin
                free_head_next = link_eff;
                if (fill_hit)
                begin
                    fill_next = e_reg + PW'(1);
                end
                tail_we = 1'b1;
                data_we = 1'b1;
                if (hempty_reg)
                begin
                    head_we                = 1'b1;
                    head_wdata             = e_reg;
                    head_vld_next[q_waddr] = 1'b1;
                end
                else if (chk_ok)
                begin
                    link_we    = 1'b1;
                    link_waddr = tail_rd;
                    link_wdata = e_reg;
                end
                state_next = S_ENQ2;
            end
            S_ENQ2:
            begin
                link_we         = 1'b1;
                link_waddr      = e_reg[IW-1:0];
                link_wdata      = NIL;
                res_data_next   = '0;
                res_status_next = sbmq_pkg::ST_DONE;
                state_next      = S_OUT;
            end
            S_DEQ:
            begin
                head_we         = 1'b1;
                head_wdata      = link_eff;
                link_we         = 1'b1;
                link_waddr      = e_reg[IW-1:0];
                link_wdata      = free_head_reg;
                free_head_next  = e_reg;
                res_data_next   = data_rd;
                res_status_next = sbmq_pkg::ST_DONE;
                state_next      = S_OUT;
            end
            S_OUT:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        out_status_next = out_status_reg;
        if (out_load)
        begin
            out_valid_next  = 1'b1;
            out_data_next   = res_data_reg;
            out_status_next = res_status_reg;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            free_head_reg <= '0;
            fill_reg      <= '0;
            head_vld_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            free_head_reg <= free_head_next;
            fill_reg      <= fill_next;
            head_vld_reg  <= head_vld_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg       <= mode_next;
        q_reg          <= q_next;
        word_reg       <= word_next;
        e_reg          <= e_next;
        hempty_reg     <= hempty_next;
        res_data_reg   <= res_data_next;
        res_status_reg <= res_status_next;
        out_data_reg   <= out_data_next;
        out_status_reg <= out_status_next;
    end

    sbmq_ram #(.WIDTH(PW), .DEPTH(QUEUES)) u_head_ram (
        .clk   (clk),
        .we    (head_we),
        .waddr (q_waddr),
        .wdata (head_wdata),
        .raddr (q_raddr),
        .rdata (head_rd)
    );

    sbmq_ram #(.WIDTH(IW), .DEPTH(QUEUES)) u_tail_ram (
        .clk   (clk),
        .we    (tail_we),
        .waddr (q_waddr),
        .wdata (e_reg[IW-1:0]),
        .raddr (q_raddr),
        .rdata (tail_rd)
    );

    sbmq_ram #(.WIDTH(PW), .DEPTH(DEPTH)) u_link_ram (
        .clk   (clk),
        .we    (link_we),
        .waddr (link_waddr),
        .wdata (link_wdata),
        .raddr (ent_raddr),
        .rdata (link_rd)
    );

    sbmq_ram #(.WIDTH(sbmq_pkg::DATA_W), .DEPTH(DEPTH)) u_data_ram (
        .clk   (clk),
        .we    (data_we),
        .waddr (e_reg[IW-1:0]),
        .wdata (word_reg),
        .raddr (ent_raddr),
        .rdata (data_rd)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_status_reg;

`ifndef NO_ASSERTIONS
    // fill count and free head never pass the null mark
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (fill_reg <= NIL) && (free_head_reg <= NIL))
        else $error("fill count or free head out of range");

    // a new result beat only appears out of the output state
    a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(state_reg == S_OUT))
        else $error("result appeared outside output state");

    // a successful dequeue hands its entry back to the free list
    a_deq_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DEQ) |=> (free_head_reg == $past(e_reg)))
        else $error("dequeued entry not returned to free list");

    // status code is always one of the three defined values
    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser != 2'd3))
        else $error("undefined status code on result");
`endif

endmodule

FILE: rtl/sbmq_ram.sv
// sbmq_ram: generic single-write, single-read ram with registered read data
// used for every store of the multi-queue block; no dependencies
`timescale 1ns / 1ps

module sbmq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: tb/sv/shared_buffer_multi_queue_test.sv
// shared_buffer_multi_queue_test: self-checking bench for the shared-buffer multi-queue
// runs a directed table then phased random enqueue/dequeue traffic against a built-in predictor
// depends on sbmq_pkg and shared_buffer_multi_queue
`timescale 1ns / 1ps

module shared_buffer_multi_queue_test;
    import sbmq_pkg::*;

    localparam int DEPTH       = DEPTH_DEF;
    localparam int QUEUES      = QUEUES_DEF;
    localparam int SLOT_W      = $clog2(DEPTH);
    localparam int IX_W        = $clog2(DEPTH) + 1;
    localparam int RAND_ITEMS  = 1300;
    localparam int HOLD_CYCLES = 300;
    localparam int CYCLE_LIMIT = 400000;
    localparam int ROWS        = 25;

    localparam logic [IX_W-1:0] NULL_IX = IX_W'(DEPTH);

    typedef struct packed {
        logic [DATA_W-1:0] word;
        logic [ST_W-1:0]   status;
    } outcome_t;

    typedef struct packed {
        logic              mode;
        logic [QID_W-1:0]  qid;
        logic [DATA_W-1:0] word;
        logic              fixed;
        outcome_t          answer;
    } req_row_t;

    logic                clk;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    logic [DATA_W-1:0]   s_tdata;
    logic [QID_W:0]      s_tuser;
    logic                m_tvalid;
    logic                m_tready;
    logic [DATA_W-1:0]   m_tdata;
    logic [ST_W-1:0]     m_tuser;

    // shadow copy of the linked-list store
    logic [DATA_W-1:0]   slot_word [DEPTH];
    logic [IX_W-1:0]     slot_next [DEPTH];
    logic [IX_W-1:0]     q_first   [QUEUES];
    logic [IX_W-1:0]     q_last    [QUEUES];
    logic [IX_W-1:0]     free_top;

    outcome_t            pending_results [$];
    int                  mismatch_cnt;
    int                  cycle_cnt;
    int                  send_calm;
    int                  recv_calm;
    logic                hold_out;

    // rows with fixed=1 carry an answer readable straight off the spec
    req_row_t directed_rows [ROWS] = '{
        '{MODE_DEQ, 2'd0, 32'h0000_0000, 1'b1, '{32'h0, ST_EMPTY}},
        '{MODE_DEQ, 2'd1, 32'hffff_ffff, 1'b1, '{32'h0, ST_EMPTY}},
        '{MODE_DEQ, 2'd2, 32'h0000_0000, 1'b1, '{32'h0, ST_EMPTY}},
        '{MODE_DEQ, 2'd3, 32'hffff_ffff, 1'b1, '{32'h0, ST_EMPTY}},
        '{MODE_ENQ, 2'd0, 32'h7fff_ffff, 1'b0, '{32'h0, ST_DONE}},
        '{MODE_ENQ, 2'd0, 32'h8000_0000, 1'b0, '{32'h0, ST_DONE}},
        '{MODE_ENQ, 2'd1, 32'hffff_ffff, 1'b0, '{32'h0, ST_DONE}},
        '{MODE_ENQ, 2'd1, 32'h0000_0000, 1'b0, '{32'h0, ST_DONE}},
        '{MODE_ENQ, 2'd2, 32'h0000_0001, 1'b0, '{32'h0, ST_DONE}},
        '{MODE_ENQ, 2'd3, 32'hffff_fffe, 1'b0, '{32'h0, ST_DONE}},
        '{MODE_ENQ, 2'd3, 32'h5555_5555, 1'b0, '{32'h0, ST_DONE}},
        '{MODE_ENQ, 2'd2, 32'haaaa_aaaa, 1'b0, '{32'h0, ST_DONE}},
        '{MODE_ENQ, 2'd0, 32'h0000_0010, 1'b0, '{32'h0, ST_DONE}},
        '{MODE_ENQ, 2'd1, 32'h8000_0001, 1'b0, '{32'h0, ST_DONE}},
        '{MODE_ENQ, 2'd2, 32'h7fff_fffe, 1'b0, '{32'h0, ST_DONE}},
        '{MODE_ENQ, 2'd3, 32'h0f0f_0f0f, 1'b0, '{32'h0, ST_DONE}},
        '{MODE_ENQ, 2'd0, 32'hf0f0_f0f0, 1'b0, '{32'h0, ST_DONE}},
        '{MODE_ENQ, 2'd1, 32'h1234_5678, 1'b0, '{32'h0, ST_DONE}},
        '{MODE_ENQ, 2'd2, 32'h8765_4321, 1'b0, '{32'h0, ST_DONE}},
        '{MODE_ENQ, 2'd3, 32'hcafe_f00d, 1'b0, '{32'h0, ST_DONE}},
        '{MODE_ENQ, 2'd1, 32'hdead_beef, 1'b1, '{32'h0, ST_FULL}},
        '{MODE_DEQ, 2'd0, 32'h0000_0000, 1'b0, '{32'h0, ST_DONE}},
        '{MODE_DEQ, 2'd3, 32'h0000_0000, 1'b0, '{32'h0, ST_DONE}},
        '{MODE_ENQ, 2'd3, 32'hbeef_0001, 1'b0, '{32'h0, ST_DONE}},
        '{MODE_DEQ, 2'd1, 32'h0000_0000, 1'b0, '{32'h0, ST_DONE}}
    };

    shared_buffer_multi_queue u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #4 clk = ~clk;
        end
    end

    // idle cycles before the next beat, with runs of back-to-back beats
    function automatic int draw_gap(inout int calm_left);
        if (calm_left > 0)
        begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 9) == 0)
        begin
            calm_left = $urandom_range(15, 50);
            return 0;
        end
        return $urandom_range(0, 17);
    endfunction

    // advance the shadow store by one request and give its outcome
    function automatic outcome_t apply_request(input logic mode, input logic [QID_W-1:0] qid,
                                               input logic [DATA_W-1:0] word);
        outcome_t        res;
        logic [IX_W-1:0] e;
        res.word = '0;
        if (mode == MODE_ENQ)
        begin
            if (qid >= QUEUES || free_top >= DEPTH)
            begin
                res.status = ST_FULL;
            end
            else
            begin
                e = free_top;
                free_top = slot_next[e[SLOT_W-1:0]];
                if (q_first[qid] >= DEPTH)
                begin
                    q_first[qid] = e;
                end
                else if (q_last[qid] < DEPTH)
                begin
                    slot_next[q_last[qid][SLOT_W-1:0]] = e;
                end
                slot_next[e[SLOT_W-1:0]] = NULL_IX;
                q_last[qid]  = e;
                slot_word[e[SLOT_W-1:0]] = word;
                res.status   = ST_DONE;
            end
        end
        else
        begin
            if (qid >= QUEUES || q_first[qid] >= DEPTH)
            begin
                res.status = ST_EMPTY;
            end
            else
            begin
                e = q_first[qid];
                q_first[qid] = slot_next[e[SLOT_W-1:0]];
                slot_next[e[SLOT_W-1:0]] = (free_top < DEPTH) ? free_top : NULL_IX;
                free_top     = e;
                res.word     = slot_word[e[SLOT_W-1:0]];
                res.status   = ST_DONE;
            end
        end
        return res;
    endfunction

    task automatic send_request(input req_row_t row);
        int       gap;
        outcome_t predicted;
        gap = draw_gap(send_calm);
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tdata  = row.word;
        s_tuser  = {row.qid, row.mode};
        s_tvalid = 1'b1;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        predicted = apply_request(row.mode, row.qid, row.word);
        pending_results.push_back(row.fixed ? row.answer : predicted);
    endtask

    // result checker
    always @(posedge clk)
    begin
        outcome_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
            begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                    $display("unexpected beat: data %h status %0d", m_tdata, m_tuser);
            end
            else
            begin
                want = pending_results.pop_front();
                if (m_tdata !== want.word || m_tuser !== want.status)
                begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("mismatch: expected data %h status %0d, got data %h status %0d",
                                 want.word, want.status, m_tdata, m_tuser);
                end
            end
        end
    end

    // result receiver, with one long hold-off on request
    initial
    begin
        int gap;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_out)
            begin
                m_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_out = 1'b0;
            end
            gap = draw_gap(recv_calm);
            if (gap > 0)
            begin
                m_tready = 1'b0;
                repeat (gap) @(negedge clk);
            end
            m_tready = 1'b1;
            @(posedge clk);
            while (!m_tvalid) @(posedge clk);
        end
    end

    initial
    begin
        cycle_cnt = 0;
        while (cycle_cnt < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        req_row_t row;
        int       done_items;
        int       phase_len;
        int       enq_pct;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = '0;
        rst_n        = 1'b0;
        mismatch_cnt = 0;
        send_calm    = 0;
        recv_calm    = 0;
        hold_out     = 1'b0;
        for (int i = 0; i < DEPTH; i++)
        begin
            slot_word[i] = '0;
            slot_next[i] = IX_W'(i + 1);
        end
        for (int i = 0; i < QUEUES; i++)
        begin
            q_first[i] = NULL_IX;
            q_last[i]  = '0;
        end
        free_top = '0;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (directed_rows[i])
            send_request(directed_rows[i]);

        // most phases lean toward filling or draining so both full and empty recur
        done_items = 0;
        while (done_items < RAND_ITEMS)
        begin
            phase_len = $urandom_range(20, 80);
            case ($urandom_range(0, 3))
                0:       enq_pct = 25;
                1:       enq_pct = 50;
                2:       enq_pct = 75;
                default: enq_pct = 90;
            endcase
            for (int k = 0; k < phase_len && done_items < RAND_ITEMS; k++)
            begin
                row.mode  = ($urandom_range(0, 99) < enq_pct) ? MODE_ENQ : MODE_DEQ;
                row.qid   = QID_W'($urandom_range(0, 3));
                case ($urandom_range(0, 7))
                    0:       row.word = 32'h7fff_ffff;
                    1:       row.word = 32'h8000_0000;
                    default: row.word = $urandom;
                endcase
                row.fixed  = 1'b0;
                row.answer = '0;
                if (done_items == 40)
                    hold_out = 1'b1;
                send_request(row);
                done_items++;
            end
        end
        @(negedge clk);
        s_tvalid = 1'b0;

        while (pending_results.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        if (mismatch_cnt == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

FILE: sim.f
rtl/sbmq_pkg.sv
rtl/sbmq_ram.sv
rtl/shared_buffer_multi_queue.sv
tb/sv/shared_buffer_multi_queue_test.sv
